// ----- src/lpue_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel UART encoder package
// Shared types, constants and the bit-pair symbol table.
// ----------------------------------------------------------------------------
package lpue_pkg;

    localparam int unsigned COLOR_ORDER_W  = 6;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned CFG_DATA_W     = 8;
    localparam int unsigned NUM_SLOTS      = 4;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [COLOR_ORDER_W-1:0] COLOR_ORDER_RESET = 6'd36;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ORDER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_WHITE   = 2'd1;

    // UART bytes for the four bit pairs.
    localparam logic [7:0] SYM_PAIR_00 = 8'hEF;
    localparam logic [7:0] SYM_PAIR_01 = 8'hCF;
    localparam logic [7:0] SYM_PAIR_10 = 8'hEE;
    localparam logic [7:0] SYM_PAIR_11 = 8'hCE;

    // Last slot index depending on white mode.
    localparam logic [1:0] LAST_SLOT_RGB  = 2'd2;
    localparam logic [1:0] LAST_SLOT_RGBW = 2'd3;
    localparam logic [1:0] LAST_PAIR      = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
        logic       final_pixel;
    } pixel_t;

    typedef struct packed {
        logic [7:0] uart_symbol;
        logic       pixel_done;
        logic       frame_done;
    } symbol_t;

    // One classified pixel waiting between front and back.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][7:0] slot_bytes;
        logic                      has_white;
        logic                      final_pixel;
    } entry_t;

    function automatic logic [7:0] pair_symbol(input logic [1:0] pair);
        logic [7:0] sym;
        unique case (pair)
            2'b00:   sym = SYM_PAIR_00;
            2'b01:   sym = SYM_PAIR_01;
            2'b10:   sym = SYM_PAIR_10;
            default: sym = SYM_PAIR_11;
        endcase
        return sym;
    endfunction

endpackage

// ----- src/led_pixel_uart_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel UART encoder
// Turns pixels into UART bytes carrying two strip data bits each.
// ----------------------------------------------------------------------------
// Each pixel pushed in yields twelve UART symbol items (sixteen in white
// mode), one per clock cycle on the result side while the consumer keeps
// popping; the single symbol serialiser in the back end sets the pace of
// a steady pixel stream. The front end places red, green and blue into
// the wire slots named by the colour order register (bits 1:0 red, 3:2
// green, 5:4 blue; reset order red, green, blue), puts white into slot 3 in
// white mode, and pushes the result into a short pixel queue. Where two
// colours name the same slot the later one wins in the order red, green,
// blue, white; an unnamed slot sends zero, and a colour sent to slot 3
// without white mode is dropped. The back end reads the queue head and
// emits its slots in order, most significant bit pair first, marking the
// last symbol of each pixel and, for a pixel flagged as the frame's last,
// also the end of frame. A pixel enters the queue as soon as there is room,
// so input and output stall independently. Configuration writes are always
// ready and take effect at once; they should only be issued while the
// block is idle. Unknown register indexes are ignored.
// ----------------------------------------------------------------------------
module led_pixel_uart_encoder_core #(
    parameter int unsigned QueueDepth = lpue_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpue_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpue_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Pixel side
    input  logic                             push,
    output logic                             full,
    input  lpue_pkg::pixel_t                 pixel,
    // Symbol side
    output logic                             empty,
    input  logic                             pop,
    output lpue_pkg::symbol_t                symbol
);

    lpue_pkg::entry_t front_entry;
    lpue_pkg::entry_t head_entry;
    logic             queue_full;
    logic             queue_empty;
    logic             queue_wr;
    logic             queue_rd;

    // Registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    assign full     = queue_full;
    assign queue_wr = push && !queue_full;

    lpue_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel),
        .entry     (front_entry)
    );

    lpue_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (queue_wr),
        .wr_entry (front_entry),
        .full     (queue_full),
        .rd_en    (queue_rd),
        .rd_entry (head_entry),
        .empty    (queue_empty)
    );

    lpue_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_entry),
        .head_empty (queue_empty),
        .head_pop   (queue_rd),
        .symbol     (symbol),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ----- src/lpue_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel UART encoder front end
// Holds the configuration registers and places each pixel into wire slots.
// ----------------------------------------------------------------------------
module lpue_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [lpue_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpue_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  lpue_pkg::pixel_t                 pixel,
    output lpue_pkg::entry_t                 entry
);

    logic [lpue_pkg::COLOR_ORDER_W-1:0] color_order_reg;
    logic [lpue_pkg::COLOR_ORDER_W-1:0] color_order_next;
    logic                               has_white_reg;
    logic                               has_white_next;

    always_comb
    begin
        color_order_next = color_order_reg;
        has_white_next   = has_white_reg;
        if (cfg_valid)
        begin
            if (cfg_index == lpue_pkg::REG_COLOR_ORDER)
            begin
                color_order_next = cfg_data[lpue_pkg::COLOR_ORDER_W-1:0];
            end
            else if (cfg_index == lpue_pkg::REG_HAS_WHITE)
            begin
                has_white_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_order_reg <= lpue_pkg::COLOR_ORDER_RESET;
            has_white_reg   <= 1'b0;
        end
        else
        begin
            color_order_reg <= color_order_next;
            has_white_reg   <= has_white_next;
        end
    end

    // Later writes win on a collision: red, then green, blue and white.
    always_comb
    begin
        entry.slot_bytes                       = '0;
        entry.slot_bytes[color_order_reg[1:0]] = pixel.red;
        entry.slot_bytes[color_order_reg[3:2]] = pixel.green;
        entry.slot_bytes[color_order_reg[5:4]] = pixel.blue;
        if (has_white_reg)
        begin
            entry.slot_bytes[lpue_pkg::LAST_SLOT_RGBW] = pixel.white;
        end
        entry.has_white   = has_white_reg;
        entry.final_pixel = pixel.final_pixel;
    end

endmodule

// ----- src/lpue_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel UART encoder pixel queue
// Short first-in first-out queue of classified pixels.
// ----------------------------------------------------------------------------
module lpue_queue #(
    parameter int unsigned Depth = lpue_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  lpue_pkg::entry_t wr_entry,
    output logic             full,
    input  logic             rd_en,
    output lpue_pkg::entry_t rd_entry,
    output logic             empty
);

    localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CountW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0]   PtrLast  = PtrW'(Depth - 1);
    localparam logic [CountW-1:0] CountMax = CountW'(Depth);

    lpue_pkg::entry_t store_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CountW-1:0] count_reg;

    assign full     = (count_reg == CountMax);
    assign empty    = (count_reg == '0);
    assign rd_entry = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/lpue_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pixel UART encoder back end
// Walks the bit pairs of the head pixel and fills the output register.
// ----------------------------------------------------------------------------
module lpue_back (
    input  logic             clk,
    input  logic             rst_n,
    input  lpue_pkg::entry_t head,
    input  logic             head_empty,
    output logic             head_pop,
    output lpue_pkg::symbol_t symbol,
    output logic             empty,
    input  logic             pop
);

    logic [3:0]        sym_idx_reg;
    logic [3:0]        sym_idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    lpue_pkg::symbol_t out_reg;
    lpue_pkg::symbol_t out_next;

    logic       load;
    logic [1:0] slot;
    logic [1:0] pair_pos;
    logic [1:0] last_slot;
    logic [7:0] cur_byte;
    logic [1:0] pair;
    logic       last;

    assign slot      = sym_idx_reg[3:2];
    assign pair_pos  = sym_idx_reg[1:0];
    assign last_slot = head.has_white ? lpue_pkg::LAST_SLOT_RGBW : lpue_pkg::LAST_SLOT_RGB;
    assign cur_byte  = head.slot_bytes[slot];
    assign last      = (slot == last_slot) && (pair_pos == lpue_pkg::LAST_PAIR);
    assign load      = !head_empty && (!out_valid_reg || pop);
    assign head_pop  = load && last;

    // Most significant pair first.
    always_comb
    begin
        unique case (pair_pos)
            2'd0:    pair = cur_byte[7:6];
            2'd1:    pair = cur_byte[5:4];
            2'd2:    pair = cur_byte[3:2];
            default: pair = cur_byte[1:0];
        endcase
    end

    always_comb
    begin
        sym_idx_next   = sym_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.uart_symbol = lpue_pkg::pair_symbol(pair);
            out_next.pixel_done  = last;
            out_next.frame_done  = last && head.final_pixel;
            sym_idx_next         = last ? '0 : sym_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sym_idx_reg   <= sym_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign symbol = out_reg;
    assign empty  = !out_valid_reg;

endmodule
